/* rtl/core/assert_macros.svh */
// Assertion macros for the top level of the span generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/core/fcsg_pkg.sv */
// Package with the types and constants shared by the span generator modules.
package fcsg_pkg;

    // Width of every coordinate result field, in two's complement.
    localparam int OUT_BITS = 14;

    // Most results produced for one circle.
    localparam int MAX_RESULTS = 64;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // latch a new circle and start the iteration
        logic step;   // register one result and advance the iteration
    } fcsg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;   // the result of the current iteration ends the circle
    } fcsg_status_t;

endpackage

/* rtl/core/fcsg_ctrl.sv */
// Controller state machine of the span generator: input and output handshakes.
module fcsg_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fcsg_pkg::fcsg_cmd_t    cmd,
    input  fcsg_pkg::fcsg_status_t status
);
    import fcsg_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   step;

    // A step may proceed when the output register is empty or is being drained.
    assign step = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.load  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.step  = step;

endmodule

/* rtl/core/fcsg_dp.sv */
// Datapath of the span generator: midpoint iteration and result registers.
module fcsg_dp #(
    parameter int RADIUS_BITS = 6,
    parameter int COORD_BITS  = 12
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fcsg_pkg::fcsg_cmd_t                   cmd,
    output fcsg_pkg::fcsg_status_t                status,
    input  logic [COORD_BITS-1:0]                 center_x,
    input  logic [COORD_BITS-1:0]                 center_y,
    input  logic [RADIUS_BITS-1:0]                radius,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  wide_left,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  wide_right,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  narrow_left,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  narrow_right,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  row_wide_below,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  row_wide_above,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  row_narrow_below,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  row_narrow_above,
    output logic                                  last
);
    import fcsg_pkg::*;

    // Offsets stay within -1 .. radius; the decision term within about +-4 radius.
    localparam int OFS_W = RADIUS_BITS + 2;
    localparam int DEC_W = RADIUS_BITS + 4;
    localparam int SUM_W = ((COORD_BITS + 1 > OFS_W) ? COORD_BITS + 1 : OFS_W) + 1;
    localparam int EXT_W = (SUM_W > OUT_BITS) ? SUM_W : OUT_BITS;

    logic signed [OFS_W-1:0]       x_reg, x_next;
    logic signed [OFS_W-1:0]       y_reg, y_next;
    logic signed [DEC_W-1:0]       d_reg, d_next;
    logic [COORD_BITS-1:0]         cx_reg;
    logic [COORD_BITS-1:0]         cy_reg;
    logic [RADIUS_BITS-1:0]        r_reg;
    logic [CNT_BITS-1:0]           cnt_reg;

    logic signed [OUT_BITS-1:0]    wl_reg, wr_reg, nl_reg, nr_reg;
    logic signed [OUT_BITS-1:0]    rwb_reg, rwa_reg, rnb_reg, rna_reg;
    logic                          last_reg;

    logic signed [DEC_W-1:0]       x_d, y_d, r_d;
    logic signed [EXT_W-1:0]       cx_e, cy_e, x_e, y_e;
    logic                          last_now;

    assign x_d  = DEC_W'(x_reg);
    assign y_d  = DEC_W'(y_reg);
    assign r_d  = $signed({{(DEC_W - RADIUS_BITS){1'b0}}, r_reg});
    assign cx_e = $signed({{(EXT_W - COORD_BITS){1'b0}}, cx_reg});
    assign cy_e = $signed({{(EXT_W - COORD_BITS){1'b0}}, cy_reg});
    assign x_e  = EXT_W'(x_reg);
    assign y_e  = EXT_W'(y_reg);

    // One midpoint step: move right, move down, or move diagonally.
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        d_next = d_reg;
        if (d_reg >= (x_d <<< 1))
        begin
            d_next = d_reg - (x_d <<< 1) - DEC_W'(1);
            x_next = x_reg + OFS_W'(1);
        end
        else if (d_reg < ((r_d - y_d) <<< 1))
        begin
            d_next = d_reg + (y_d <<< 1) - DEC_W'(1);
            y_next = y_reg - OFS_W'(1);
        end
        else
        begin
            d_next = d_reg + ((y_d - x_d - DEC_W'(1)) <<< 1);
            y_next = y_reg - OFS_W'(1);
            x_next = x_reg + OFS_W'(1);
        end
    end

    assign last_now    = (y_next < x_next) || (cnt_reg == CNT_BITS'(MAX_RESULTS - 1));
    assign status.last = last_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            d_reg   <= '0;
            cx_reg  <= '0;
            cy_reg  <= '0;
            r_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            r_reg   <= radius;
            x_reg   <= '0;
            y_reg   <= $signed({{(OFS_W - RADIUS_BITS){1'b0}}, radius});
            d_reg   <= $signed({{(DEC_W - RADIUS_BITS){1'b0}}, radius}) - DEC_W'(1);
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            d_reg   <= d_next;
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
    end

    // Result registers take the spans of the current offsets.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            wl_reg   <= OUT_BITS'(cx_e - y_e);
            wr_reg   <= OUT_BITS'(cx_e + y_e);
            nl_reg   <= OUT_BITS'(cx_e - x_e);
            nr_reg   <= OUT_BITS'(cx_e + x_e);
            rwb_reg  <= OUT_BITS'(cy_e + x_e);
            rwa_reg  <= OUT_BITS'(cy_e - x_e);
            rnb_reg  <= OUT_BITS'(cy_e + y_e);
            rna_reg  <= OUT_BITS'(cy_e - y_e);
            last_reg <= last_now;
        end
    end

    assign wide_left        = wl_reg;
    assign wide_right       = wr_reg;
    assign narrow_left      = nl_reg;
    assign narrow_right     = nr_reg;
    assign row_wide_below   = rwb_reg;
    assign row_wide_above   = rwa_reg;
    assign row_narrow_below = rnb_reg;
    assign row_narrow_above = rna_reg;
    assign last             = last_reg;

endmodule

/* rtl/core/filled_circle_span_generator.sv */
// Top level of the filled circle span generator.
//
// The input channel takes one circle per transfer: center_x, center_y and
// radius. For each circle the block walks the midpoint circle iteration and
// sends one result transfer per iteration on the output channel. Each result
// holds four horizontal spans that together fill the circle: the wide spans
// run from wide_left to wide_right on rows row_wide_below and row_wide_above,
// the narrow spans from narrow_left to narrow_right on rows row_narrow_below
// and row_narrow_above. Coordinates may go negative near the edges and are
// given in two's complement. The last result of a circle carries last = 1.
// A circle of radius r gives about 0.71 r + 1 results, never more than 64.
// After the input transfer the controller enters its run state, from which
// the first result is registered; while the receiver does not stall, the
// iteration unit then produces one result per cycle. in_ready is high
// only between circles; the next circle is taken while the final result
// still waits. If the receiver stalls, the output register holds its result
// and the iteration pauses until the transfer completes. Reset empties the
// output register and returns the block to idle, ready for a new circle.
module filled_circle_span_generator #(
    parameter int RADIUS_BITS = 6,
    parameter int COORD_BITS  = 12
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [COORD_BITS-1:0]                 center_x,
    input  logic [COORD_BITS-1:0]                 center_y,
    input  logic [RADIUS_BITS-1:0]                radius,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  wide_left,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  wide_right,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  narrow_left,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  narrow_right,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  row_wide_below,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  row_wide_above,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  row_narrow_below,
    output logic signed [fcsg_pkg::OUT_BITS-1:0]  row_narrow_above,
    output logic                                  last
);
    import fcsg_pkg::*;

`include "assert_macros.svh"

    fcsg_cmd_t    cmd;
    fcsg_status_t status;

    // The controller owns both handshakes and decides when the iteration moves.
    fcsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the circle, the iteration registers and the result.
    fcsg_dp #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .center_x         (center_x),
        .center_y         (center_y),
        .radius           (radius),
        .wide_left        (wide_left),
        .wide_right       (wide_right),
        .narrow_left      (narrow_left),
        .narrow_right     (narrow_right),
        .row_wide_below   (row_wide_below),
        .row_wide_above   (row_wide_above),
        .row_narrow_below (row_narrow_below),
        .row_narrow_above (row_narrow_above),
        .last             (last)
    );

    // An accepted circle always yields at least one result, so the block is busy next.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // A stalled result stays offered, with wide_left and last unchanged, until the receiver takes it.
    `ASSERT_NEXT(a_hold_while_stalled, clk, rst_n, out_valid && !out_ready, out_valid && $stable(wide_left) && $stable(last))
    // A pending result that is not the last one keeps the circle in progress.
    `ASSERT_IMPLIES(a_more_means_busy, clk, rst_n, out_valid && !last, !in_ready)

endmodule
